@@ design/sal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types, constants and the CORDIC step-angle table for the steering
// angle unit.
// ----------------------------------------------------------------------------
package sal_pkg;

    // coordinate and angle formats
    localparam int FRAC_BITS      = 8;
    localparam int ANGLE_BITS     = 9;
    localparam int MAG_BITS       = 8;
    localparam int Z_BITS         = 18;
    localparam int ATAN_LEN       = 24;
    localparam int ATAN_IDX_BITS  = 5;
    localparam int RIGHT_ANGLE    = 90;
    localparam int STRAIGHT_ANGLE = 180;

    // line count codes
    localparam logic [1:0] LC_ONE = 2'd1;
    localparam logic [1:0] LC_TWO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CENTER_X       = 2'd0;
    localparam logic [1:0] REG_BOTTOM_Y       = 2'd1;
    localparam logic [1:0] REG_FALLBACK_ANGLE = 2'd2;

    typedef logic [ATAN_IDX_BITS-1:0] step_idx_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      step;
        logic      commit;
        step_idx_t step_idx;
    } sal_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic iter_needed;
    } sal_status_t;

    // configuration values
    typedef struct packed {
        logic [7:0] center_x;
        logic [7:0] bottom_y;
        logic [7:0] fallback_angle;
    } sal_cfg_t;

    // atan(2^-i) in degrees, 8 fraction bits, rounded to nearest
    function automatic logic [13:0] atan_q8(input step_idx_t idx);
        logic [13:0] v;
        case (idx)
            5'd0:    v = 14'd11520;
            5'd1:    v = 14'd6801;
            5'd2:    v = 14'd3593;
            5'd3:    v = 14'd1824;
            5'd4:    v = 14'd916;
            5'd5:    v = 14'd458;
            5'd6:    v = 14'd229;
            5'd7:    v = 14'd115;
            5'd8:    v = 14'd57;
            5'd9:    v = 14'd29;
            5'd10:   v = 14'd14;
            5'd11:   v = 14'd7;
            5'd12:   v = 14'd4;
            5'd13:   v = 14'd2;
            5'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/sal_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_ctrl
// Sequencer: takes an item, runs the CORDIC iterations for an item with two
// lines, then commits the result into the output register once it is free.
// ----------------------------------------------------------------------------
module sal_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  sal_pkg::sal_status_t status,
    output sal_pkg::sal_cmd_t    cmd
);
    import sal_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int IW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            out_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.commit     = 1'b0;
        cmd.step_idx   = step_idx_t'(idx_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = status.iter_needed ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(NSTEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/sal_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_datapath
// Midpoint and vector setup, one shared CORDIC vectoring stage used once per
// step, restore-angle rule, and the held angle / output registers.
// ----------------------------------------------------------------------------
module sal_datapath #(
    parameter int COORD_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sal_pkg::sal_cmd_t         cmd,
    output sal_pkg::sal_status_t      status,
    input  sal_pkg::sal_cfg_t         cfg,
    input  logic [1:0]                line_count,
    input  logic [7:0]                first_end_x,
    input  logic [7:0]                first_end_y,
    input  logic [7:0]                second_end_x,
    input  logic [7:0]                second_end_y,
    input  logic                      first_present,
    input  logic                      second_present,
    input  logic [7:0]                third_start_x,
    output logic signed [sal_pkg::ANGLE_BITS-1:0] steer_deg,
    output logic                      angle_updated
);
    import sal_pkg::*;

    localparam int         CW    = (COORD_BITS < 8) ? COORD_BITS : 8;
    localparam logic [7:0] CMASK = 8'((9'd1 << CW) - 9'd1);
    localparam int         W     = 8 + FRAC_BITS + 4;

    // coordinate setup
    logic [7:0]         x0, y0, x1, y1;
    logic [8:0]         sum_x, sum_y;
    logic [7:0]         mx, my;
    logic signed [8:0]  dx, dy;
    logic [7:0]         ay, ady;

    assign x0    = first_end_x & CMASK;
    assign y0    = first_end_y & CMASK;
    assign x1    = second_end_x & CMASK;
    assign y1    = second_end_y & CMASK;
    assign sum_x = {1'b0, x0} + {1'b0, x1};
    assign sum_y = {1'b0, y0} + {1'b0, y1};
    assign mx    = sum_x[8:1];
    assign my    = sum_y[8:1];
    assign dx    = $signed({1'b0, mx}) - $signed({1'b0, cfg.center_x});
    assign dy    = $signed({1'b0, cfg.bottom_y}) - $signed({1'b0, my});
    assign ay    = dx[8] ? 8'(-dx) : dx[7:0];
    assign ady   = dy[8] ? 8'(-dy) : dy[7:0];

    assign status.iter_needed = (line_count == LC_TWO);

    // restore-angle rule for a single line
    logic [7:0]                  r_mag;
    logic                        r_pos;
    logic signed [ANGLE_BITS-1:0] r_angle;

    assign r_mag = (cfg.fallback_angle > 8'(STRAIGHT_ANGLE)) ? 8'(STRAIGHT_ANGLE)
                                                              : cfg.fallback_angle;
    always_comb
    begin
        if (first_present)
            r_pos = 1'b0;
        else if (second_present)
            r_pos = 1'b1;
        else
            r_pos = (third_start_x >= cfg.center_x);
    end
    assign r_angle = r_pos ? $signed({1'b0, r_mag}) : -$signed({1'b0, r_mag});

    // item registers
    logic [1:0]                   mode_reg;
    logic                         dx_neg_reg, dy_neg_reg, ay_zero_reg, dy_zero_reg;
    logic signed [ANGLE_BITS-1:0] r_angle_reg;
    logic signed [W-1:0]          x_reg, y_reg;
    logic signed [Z_BITS-1:0]     z_reg;

    // one CORDIC vectoring step
    logic signed [W-1:0]      x_sh, y_sh, x_next, y_next;
    logic signed [Z_BITS-1:0] z_next, step_ang;

    assign x_sh     = x_reg >>> cmd.step_idx;
    assign y_sh     = y_reg >>> cmd.step_idx;
    assign step_ang = $signed({{(Z_BITS-14){1'b0}}, atan_q8(cmd.step_idx)});

    always_comb
    begin
        if (!y_reg[W-1])
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + step_ang;
        end
        else
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - step_ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= line_count;
            dx_neg_reg  <= dx[8];
            dy_neg_reg  <= dy[8];
            ay_zero_reg <= (ay == 8'd0);
            dy_zero_reg <= (dy == 9'sd0);
            r_angle_reg <= r_angle;
            if (!dy[8])
            begin
                x_reg <= $signed(W'({ady, {FRAC_BITS{1'b0}}}));
                y_reg <= $signed(W'({ay, {FRAC_BITS{1'b0}}}));
                z_reg <= '0;
            end
            else
            begin
                x_reg <= $signed(W'({ay, {FRAC_BITS{1'b0}}}));
                y_reg <= $signed(W'({ady, {FRAC_BITS{1'b0}}}));
                z_reg <= Z_BITS'(RIGHT_ANGLE << FRAC_BITS);
            end
        end
        else if (cmd.step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // final magnitude with special cases and clamp
    logic [Z_BITS-FRAC_BITS-1:0]  z_whole;
    logic [MAG_BITS-1:0]          mag;
    logic signed [ANGLE_BITS-1:0] v_angle;

    assign z_whole = z_reg[Z_BITS-1:FRAC_BITS];

    always_comb
    begin
        if (ay_zero_reg)
            mag = dy_neg_reg ? MAG_BITS'(STRAIGHT_ANGLE) : '0;
        else if (dy_zero_reg)
            mag = MAG_BITS'(RIGHT_ANGLE);
        else if (z_reg[Z_BITS-1])
            mag = '0;
        else if (z_whole > (Z_BITS-FRAC_BITS)'(STRAIGHT_ANGLE))
            mag = MAG_BITS'(STRAIGHT_ANGLE);
        else
            mag = z_whole[MAG_BITS-1:0];
    end
    assign v_angle = dx_neg_reg ? $signed({1'b0, mag}) : -$signed({1'b0, mag});

    // held angle and output registers
    logic signed [ANGLE_BITS-1:0] steer_deg_reg, steer_deg_next;
    logic                         angle_updated_reg, angle_updated_next;

    always_comb
    begin
        case (mode_reg)
            LC_TWO:
            begin
                steer_deg_next     = v_angle;
                angle_updated_next = 1'b1;
            end
            LC_ONE:
            begin
                steer_deg_next     = r_angle_reg;
                angle_updated_next = 1'b1;
            end
            default:
            begin
                steer_deg_next     = steer_deg_reg;
                angle_updated_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_deg_reg     <= '0;
            angle_updated_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            steer_deg_reg     <= steer_deg_next;
            angle_updated_reg <= angle_updated_next;
        end
    end

    assign steer_deg     = steer_deg_reg;
    assign angle_updated = angle_updated_reg;

endmodule

@@ design/steer_angle_from_lane_lines_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steer_angle_from_lane_lines_unit
// Steering angle from the chosen lane lines of one frame, with an APB port for
// centerline, bottom row and restore angle.
// With two lines an accepted item runs through the CORDIC iterations on the
// single iterative CORDIC stage before its result is committed; otherwise it
// goes straight to the commit, which waits while the result is stalled.
// One item is worked on at a time; a new item is taken only after the last
// result is committed.
// Reset: asynchronous, clears the held angle to 0 and restores the register
// defaults (center 39, bottom 51, restore 30); no clearing pass.
// ----------------------------------------------------------------------------
module steer_angle_from_lane_lines_unit #(
    parameter int COORD_BITS   = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input items
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             line_count,
    input  logic [7:0]                             first_end_x,
    input  logic [7:0]                             first_end_y,
    input  logic [7:0]                             second_end_x,
    input  logic [7:0]                             second_end_y,
    input  logic                                   first_present,
    input  logic                                   second_present,
    input  logic [7:0]                             third_start_x,
    // result items
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sal_pkg::ANGLE_BITS-1:0]  steer_deg,
    output logic                                   angle_updated,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [3:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import sal_pkg::*;

    logic [7:0]  center_x_reg, bottom_y_reg, fallback_angle_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;
    sal_cfg_t    cfg;
    sal_cmd_t    cmd;
    sal_status_t status;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg       <= 8'd39;
            bottom_y_reg       <= 8'd51;
            fallback_angle_reg <= 8'd30;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CENTER_X:       center_x_reg       <= pwdata[7:0];
                REG_BOTTOM_Y:       bottom_y_reg       <= pwdata[7:0];
                REG_FALLBACK_ANGLE: fallback_angle_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_CENTER_X:       prdata = {24'd0, center_x_reg};
            REG_BOTTOM_Y:       prdata = {24'd0, bottom_y_reg};
            REG_FALLBACK_ANGLE: prdata = {24'd0, fallback_angle_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.center_x       = center_x_reg;
    assign cfg.bottom_y       = bottom_y_reg;
    assign cfg.fallback_angle = fallback_angle_reg;

    // sequencer
    sal_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    sal_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .line_count     (line_count),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .first_present  (first_present),
        .second_present (second_present),
        .third_start_x  (third_start_x),
        .steer_deg      (steer_deg),
        .angle_updated  (angle_updated)
    );

endmodule

@@ test/steer_angle_from_lane_lines_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steer_angle_from_lane_lines_unit_tb
// Self-checking bench for the steering angle unit. A driver feeds frames of
// lane lines from a queue, a monitor compares every result against an
// in-bench angle predictor (midpoint vector, vectoring CORDIC, restore rule,
// hold). Register settings change between phases over the APB port, with
// readback, and both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------
module steer_angle_from_lane_lines_unit_tb;

    import sal_pkg::*;

    localparam int CORDIC_STEPS  = 16;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int NUM_PHASES    = 8;
    localparam int FRAMES_PER_PH = 170;

    // line counts that hold the angle
    localparam logic [1:0] LC_NONE  = 2'd0;
    localparam logic [1:0] LC_THREE = 2'd3;
    // register index with nothing behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] line_count;
        logic [7:0] first_end_x;
        logic [7:0] first_end_y;
        logic [7:0] second_end_x;
        logic [7:0] second_end_y;
        logic       first_present;
        logic       second_present;
        logic [7:0] third_start_x;
    } frame_t;

    typedef struct {
        logic signed [ANGLE_BITS-1:0] angle;
        logic                         updated;
    } steer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  line_count = '0;
    logic [7:0]  first_end_x = '0;
    logic [7:0]  first_end_y = '0;
    logic [7:0]  second_end_x = '0;
    logic [7:0]  second_end_y = '0;
    logic        first_present = 1'b0;
    logic        second_present = 1'b0;
    logic [7:0]  third_start_x = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [ANGLE_BITS-1:0] steer_deg;
    logic        angle_updated;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // pending frames and expected angles
    frame_t frame_q[$];
    steer_t angle_q[$];
    frame_t cur_frame;

    // predictor copy of registers and state
    logic [7:0]                   cfg_center  = 8'd39;
    logic [7:0]                   cfg_bottom  = 8'd51;
    logic [7:0]                   cfg_restore = 8'd30;
    logic signed [ANGLE_BITS-1:0] last_angle  = '0;

    logic bursts_on = 1'b1;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   quiet_cycles = 0;
    int   err_count = 0;

    steer_angle_from_lane_lines_unit #(
        .COORD_BITS   (8),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .line_count     (line_count),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .first_present  (first_present),
        .second_present (second_present),
        .third_start_x  (third_start_x),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .steer_deg      (steer_deg),
        .angle_updated  (angle_updated),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // atan(2^-i) in degrees, 8 fraction bits
    function automatic longint cordic_step_q8(input int i);
        case (i)
            0:       return 11520;
            1:       return 6801;
            2:       return 3593;
            3:       return 1824;
            4:       return 916;
            5:       return 458;
            6:       return 229;
            7:       return 115;
            8:       return 57;
            9:       return 29;
            10:      return 14;
            11:      return 7;
            12:      return 4;
            13:      return 2;
            14:      return 1;
            default: return 0;
        endcase
    endfunction

    // whole degrees of atan2(ay, dy), ay >= 0
    function automatic int arc_degrees(input longint ay, input longint dy);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        if (ay == 0)
            return dy < 0 ? STRAIGHT_ANGLE : 0;
        if (dy == 0)
            return RIGHT_ANGLE;
        if (dy > 0)
        begin
            x = dy <<< FRAC_BITS;
            y = ay <<< FRAC_BITS;
            z = 0;
        end
        else
        begin
            x = ay <<< FRAC_BITS;
            y = (-dy) <<< FRAC_BITS;
            z = longint'(RIGHT_ANGLE) <<< FRAC_BITS;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + cordic_step_q8(i);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - cordic_step_q8(i);
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            return 0;
        z = z >>> FRAC_BITS;
        if (z > STRAIGHT_ANGLE)
            z = STRAIGHT_ANGLE;
        return int'(z);
    endfunction

    // expected angle for one accepted frame
    function automatic void predict_steer(input frame_t f);
        longint mx;
        longint my;
        longint dx;
        longint dy;
        int     mag;
        int     r;
        logic   positive;
        steer_t res;
        res.updated = 1'b0;
        if (f.line_count == LC_TWO)
        begin
            mx  = (longint'(f.first_end_x) + longint'(f.second_end_x)) >>> 1;
            my  = (longint'(f.first_end_y) + longint'(f.second_end_y)) >>> 1;
            dx  = mx - longint'(cfg_center);
            dy  = longint'(cfg_bottom) - my;
            mag = arc_degrees(dx < 0 ? -dx : dx, dy);
            last_angle  = ANGLE_BITS'(dx < 0 ? mag : -mag);
            res.updated = 1'b1;
        end
        else if (f.line_count == LC_ONE)
        begin
            r = cfg_restore > STRAIGHT_ANGLE ? STRAIGHT_ANGLE : int'(cfg_restore);
            if (f.first_present)
                positive = 1'b0;
            else if (f.second_present)
                positive = 1'b1;
            else
                positive = f.third_start_x >= cfg_center;
            last_angle  = ANGLE_BITS'(positive ? r : -r);
            res.updated = 1'b1;
        end
        res.angle = last_angle;
        angle_q.push_back(res);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_steer(cur_frame);
            if (!in_valid || !in_stall)
            begin
                if (src_gap != 0)
                begin
                    src_gap  <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (frame_q.size() != 0)
                begin
                    cur_frame = frame_q.pop_front();
                    line_count     <= cur_frame.line_count;
                    first_end_x    <= cur_frame.first_end_x;
                    first_end_y    <= cur_frame.first_end_y;
                    second_end_x   <= cur_frame.second_end_x;
                    second_end_y   <= cur_frame.second_end_y;
                    first_present  <= cur_frame.first_present;
                    second_present <= cur_frame.second_present;
                    third_start_x  <= cur_frame.third_start_x;
                    in_valid       <= 1'b1;
                    if (bursts_on && $urandom_range(0, 6) == 0)
                        src_gap <= int'($urandom_range(1, 13));
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result stall
    always @(posedge clk)
    begin
        steer_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (angle_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item angle=%0d updated=%0b",
                                              steer_deg, angle_updated));
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (steer_deg !== want.angle)
                        report_mismatch($sformatf("steer_deg got %0d want %0d",
                                                  steer_deg, want.angle));
                    if (angle_updated !== want.updated)
                        report_mismatch($sformatf("angle_updated got %0b want %0b",
                                                  angle_updated, want.updated));
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap  <= sink_gap - 1;
                out_stall <= 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 8) == 0)
            begin
                sink_gap  <= int'($urandom_range(0, 12));
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X:       cfg_center  = val;
            REG_BOTTOM_Y:       cfg_bottom  = val;
            REG_FALLBACK_ANGLE: cfg_restore = val;
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [7:0] want);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[7:0] !== want)
            report_mismatch($sformatf("register %0d reads %0d want %0d", idx, got[7:0], want));
    endtask

    task automatic set_regs(input logic [7:0] cx, input logic [7:0] by, input logic [7:0] ra);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_BOTTOM_Y, by);
        write_reg(REG_FALLBACK_ANGLE, ra);
        check_reg(REG_CENTER_X, cfg_center);
        check_reg(REG_BOTTOM_Y, cfg_bottom);
        check_reg(REG_FALLBACK_ANGLE, cfg_restore);
    endtask

    task automatic push_frame(input logic [1:0] lc, input logic [7:0] x0, input logic [7:0] y0,
                              input logic [7:0] x1, input logic [7:0] y1, input logic fp,
                              input logic sp, input logic [7:0] tx);
        frame_t f;
        f.line_count     = lc;
        f.first_end_x    = x0;
        f.first_end_y    = y0;
        f.second_end_x   = x1;
        f.second_end_y   = y1;
        f.first_present  = fp;
        f.second_present = sp;
        f.third_start_x  = tx;
        frame_q.push_back(f);
    endtask

    // coordinate close to a base value
    function automatic logic [7:0] near(input int base);
        int v;
        v = base + int'($urandom_range(0, 10)) - 5;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic frame_t rand_frame();
        frame_t      f;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick < 8)
            f.line_count = LC_TWO;
        else if (pick < 12)
            f.line_count = LC_ONE;
        else
            f.line_count = pick[0] ? LC_THREE : LC_NONE;
        case ($urandom_range(0, 3))
            2:
            begin
                // midpoint near the vector origin
                f.first_end_x  = near(cfg_center);
                f.second_end_x = near(cfg_center);
                f.first_end_y  = near(cfg_bottom);
                f.second_end_y = near(cfg_bottom);
            end
            3:
            begin
                f.first_end_x  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                f.second_end_x = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                f.first_end_y  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                f.second_end_y = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                f.first_end_x  = 8'($urandom_range(0, 255));
                f.second_end_x = 8'($urandom_range(0, 255));
                f.first_end_y  = 8'($urandom_range(0, 255));
                f.second_end_y = 8'($urandom_range(0, 255));
            end
        endcase
        f.first_present  = 1'($urandom_range(0, 1));
        f.second_present = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       f.third_start_x = cfg_center;
            1:       f.third_start_x = cfg_center - 8'd1;
            default: f.third_start_x = 8'($urandom_range(0, 255));
        endcase
        return f;
    endfunction

    // wait until every queued frame has been sent and answered
    task automatic drain();
        @(negedge clk);
        while (frame_q.size() != 0 || in_valid || angle_q.size() != 0)
            @(negedge clk);
    endtask

    // stimulus and phase control
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset values readable
        check_reg(REG_CENTER_X, 8'd39);
        check_reg(REG_BOTTOM_Y, 8'd51);
        check_reg(REG_FALLBACK_ANGLE, 8'd30);

        // directed frames at reset settings
        push_frame(LC_NONE,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'd0);
        push_frame(LC_THREE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255);
        // zero vector
        push_frame(LC_TWO,   8'd39,  8'd51,  8'd39,  8'd51,  1'b0, 1'b0, 8'd0);
        // straight ahead and straight behind
        push_frame(LC_TWO,   8'd39,  8'd0,   8'd39,  8'd0,   1'b1, 1'b1, 8'd0);
        push_frame(LC_TWO,   8'd39,  8'd255, 8'd39,  8'd255, 1'b0, 1'b1, 8'd0);
        push_frame(LC_THREE, 8'd12,  8'd34,  8'd56,  8'd78,  1'b0, 1'b0, 8'd90);
        // level with the bottom row, both sides
        push_frame(LC_TWO,   8'd0,   8'd51,  8'd0,   8'd51,  1'b0, 1'b0, 8'd0);
        push_frame(LC_TWO,   8'd255, 8'd51,  8'd255, 8'd51,  1'b0, 1'b0, 8'd0);
        // extremes and floor of odd sums
        push_frame(LC_TWO,   8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0);
        push_frame(LC_TWO,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 8'd0);
        push_frame(LC_TWO,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0);
        push_frame(LC_TWO,   8'd40,  8'd50,  8'd39,  8'd51,  1'b0, 1'b0, 8'd0);
        push_frame(LC_TWO,   8'd0,   8'd0,   8'd1,   8'd1,   1'b0, 1'b0, 8'd0);
        push_frame(LC_TWO,   8'd200, 8'd10,  8'd201, 8'd11,  1'b0, 1'b0, 8'd0);
        // one line, each side rule
        push_frame(LC_ONE,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 8'd255);
        push_frame(LC_ONE,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd255);
        push_frame(LC_ONE,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0);
        push_frame(LC_ONE,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'd39);
        push_frame(LC_ONE,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'd38);
        push_frame(LC_ONE,   8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd255);
        push_frame(LC_ONE,   8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'd0);
        push_frame(LC_NONE,  8'd170, 8'd85,  8'd170, 8'd85,  1'b1, 1'b0, 8'd170);
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: ;
                1: set_regs(8'd0,   8'd0,   8'd0);
                2: set_regs(8'd255, 8'd255, 8'd180);
                3: set_regs(8'd128, 8'd255, 8'd255);
                4: set_regs(8'd255, 8'd0,   8'd181);
                5:
                begin
                    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 180)));
                    // write to an unmapped index must change nothing
                    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
                    check_reg(REG_CENTER_X, cfg_center);
                    check_reg(REG_BOTTOM_Y, cfg_bottom);
                    check_reg(REG_FALLBACK_ANGLE, cfg_restore);
                end
                default:
                    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            endcase
            // last phase runs at full rate
            if (ph == NUM_PHASES - 1)
                bursts_on = 1'b0;
            for (int n = 0; n < FRAMES_PER_PH; n++)
                frame_q.push_back(rand_frame());
            drain();
        end

        repeat (CORDIC_STEPS + 4) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
